// ===== sv/frame_timestamp_resolver_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef FRAME_TIMESTAMP_RESOLVER_ASSERT_SVH
`define FRAME_TIMESTAMP_RESOLVER_ASSERT_SVH

// Same-cycle implication.
`define FRT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("frt assertion failed");

// Next-cycle implication.
`define FRT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("frt assertion failed");

`endif

// ===== sv/frt_pkg.sv =====
`default_nettype none
package frt_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

	localparam int OP_W    = 2;
	localparam int BUS_W   = 8;
	localparam int IDENT_W = 29;
	localparam int SEC_W   = 32;
	localparam int USEC_W  = 20;
	localparam int TIME_W  = 63;
	localparam int INDEX_W = 17;
	localparam int PROD_W  = SEC_W + USEC_W;
	localparam int ENTRY_W = BUS_W + IDENT_W + TIME_W;

	localparam logic [USEC_W-1:0] MICROS_PER_SEC = USEC_W'(1000000);

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_RESOLVE = 2'd2
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_MUL,
		ST_WRITE,
		ST_CHECK_RD,
		ST_CHECK,
		ST_ECHO,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic capture;
		logic clear;
		logic mul;
		logic append_wr;
		logic rd_check;
		logic scan_init;
		logic scan_rd;
		logic load_check;
		logic load_echo;
		logic load_scan;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            idx_in_store;
		logic            count_zero;
		logic            store_full;
		logic            scan_last;
		logic            pipe_empty;
		logic            out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== sv/frt_ram.sv =====
`default_nettype none
module frt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       wr_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]                           wr_data,
	input  wire logic                                       rd_en,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic      [WIDTH-1:0]                           rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/frt_ctrl.sv =====
`default_nettype none
module frt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_ready,
	input  wire frt_pkg::sts_t sts,
	output frt_pkg::cmd_t      cmd
);

	import frt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (sts.op)
					OP_APPEND: begin
						state_d = sts.store_full ? ST_IDLE : ST_MUL;
					end
					OP_RESOLVE: begin
						if (sts.idx_in_store) begin
							state_d = ST_CHECK_RD;
						end else if (sts.count_zero) begin
							state_d = ST_ECHO;
						end else begin
							state_d = ST_SCAN;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ST_MUL:      state_d = ST_WRITE;
			ST_WRITE:    state_d = ST_IDLE;
			ST_CHECK_RD: state_d = ST_CHECK;
			ST_CHECK: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_ECHO: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (sts.pipe_empty && sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_DECODE: begin
				cmd.clear     = (sts.op == OP_CLEAR);
				cmd.scan_init = (sts.op == OP_RESOLVE) && !sts.idx_in_store;
			end
			ST_MUL:      cmd.mul = 1'b1;
			ST_WRITE:    cmd.append_wr = 1'b1;
			ST_CHECK_RD: cmd.rd_check = 1'b1;
			ST_CHECK:    cmd.load_check = sts.out_free;
			ST_ECHO:     cmd.load_echo = sts.out_free;
			ST_SCAN:     cmd.scan_rd = 1'b1;
			ST_DRAIN:    cmd.load_scan = sts.pipe_empty && sts.out_free;
			default: begin
				cmd       = '0;
				req_ready = 1'b0;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/frt_datapath.sv =====
`default_nettype none
module frt_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire frt_pkg::cmd_t                  cmd,
	output frt_pkg::sts_t                       sts,
	input  wire logic [frt_pkg::OP_W-1:0]       operation,
	input  wire logic [frt_pkg::BUS_W-1:0]      bus_number,
	input  wire logic [frt_pkg::IDENT_W-1:0]    frame_ident,
	input  wire logic [frt_pkg::SEC_W-1:0]      stamp_seconds,
	input  wire logic [frt_pkg::USEC_W-1:0]     stamp_micros,
	input  wire logic [frt_pkg::TIME_W-1:0]     record_time,
	input  wire logic signed [frt_pkg::INDEX_W-1:0] record_index,
	output logic                                rsp_valid,
	input  wire logic                           rsp_ready,
	output logic                                found,
	output logic signed [frt_pkg::INDEX_W-1:0]  result_index,
	output logic [frt_pkg::IDENT_W-1:0]         result_ident,
	output logic [frt_pkg::BUS_W-1:0]           result_bus,
	output logic [frt_pkg::TIME_W-1:0]          result_time
);

	import frt_pkg::*;

	// captured transaction
	logic [OP_W-1:0]    op_q;
	logic [BUS_W-1:0]   bus_q;
	logic [IDENT_W-1:0] ident_q;
	logic [SEC_W-1:0]   sec_q;
	logic [USEC_W-1:0]  usec_q;
	logic [TIME_W-1:0]  rtime_q;
	logic [INDEX_W-1:0] ridx_q;
	logic [PROD_W-1:0]  prod_q;

	logic [CNT_W-1:0]   count_q;
	logic [ADDR_W-1:0]  scan_addr_q;

	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic [ENTRY_W-1:0] rd_data;
	logic [BUS_W-1:0]   rd_bus;
	logic [IDENT_W-1:0] rd_ident;
	logic [TIME_W-1:0]  rd_time;
	logic               rd_match;
	logic [TIME_W-1:0]  rd_dist;

	// scan pipeline
	logic               valid_s1;
	logic [ADDR_W-1:0]  idx_s1;
	logic               valid_s2;
	logic               match_s2;
	logic [ADDR_W-1:0]  idx_s2;
	logic [BUS_W-1:0]   bus_s2;
	logic [IDENT_W-1:0] ident_s2;
	logic [TIME_W-1:0]  time_s2;
	logic [TIME_W-1:0]  dist_s2;

	// best exact match and best overall
	logic               mfound_q;
	logic [TIME_W-1:0]  mbest_q;
	logic [ADDR_W-1:0]  midx_q;
	logic [TIME_W-1:0]  mtime_q;
	logic               afound_q;
	logic [TIME_W-1:0]  abest_q;
	logic [ADDR_W-1:0]  aidx_q;
	logic [BUS_W-1:0]   abus_q;
	logic [IDENT_W-1:0] aident_q;
	logic [TIME_W-1:0]  atime_q;
	logic               m_upd;
	logic               a_upd;

	logic               load_any;

	assign wr_data = {bus_q, ident_q, TIME_W'(prod_q) + TIME_W'(usec_q)};
	assign rd_en   = cmd.rd_check || cmd.scan_rd;
	assign rd_addr = cmd.scan_rd ? scan_addr_q : ridx_q[ADDR_W-1:0];

	frt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk    (clk),
		.wr_en  (cmd.append_wr),
		.wr_addr(count_q[ADDR_W-1:0]),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	assign {rd_bus, rd_ident, rd_time} = rd_data;
	assign rd_match = (rd_bus == bus_q) && (rd_ident == ident_q);
	assign rd_dist  = (rd_time > rtime_q) ? (rd_time - rtime_q) : (rtime_q - rd_time);

	assign m_upd = valid_s2 && match_s2 && (!mfound_q || (dist_s2 < mbest_q));
	assign a_upd = valid_s2 && (!afound_q || (dist_s2 < abest_q));

	assign sts.op           = op_q;
	assign sts.idx_in_store = !ridx_q[INDEX_W-1] && (32'(ridx_q[INDEX_W-2:0]) < 32'(count_q));
	assign sts.count_zero   = (count_q == '0);
	assign sts.store_full   = (32'(count_q) == 32'(STORE_DEPTH));
	assign sts.scan_last    = (32'(scan_addr_q) + 32'd1 == 32'(count_q));
	assign sts.pipe_empty   = !valid_s1 && !valid_s2;
	assign sts.out_free     = !rsp_valid || rsp_ready;

	assign load_any = cmd.load_check || cmd.load_echo || cmd.load_scan;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			mfound_q  <= 1'b0;
			afound_q  <= 1'b0;
			rsp_valid <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			valid_s1 <= cmd.scan_rd;
			valid_s2 <= valid_s1;
			if (cmd.scan_init) begin
				mfound_q <= 1'b0;
				afound_q <= 1'b0;
			end else begin
				if (m_upd) begin
					mfound_q <= 1'b1;
				end
				if (a_upd) begin
					afound_q <= 1'b1;
				end
			end
			if (load_any) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= operation;
			bus_q   <= bus_number;
			ident_q <= frame_ident;
			sec_q   <= stamp_seconds;
			usec_q  <= stamp_micros;
			rtime_q <= record_time;
			ridx_q  <= record_index;
		end
		if (cmd.mul) begin
			prod_q <= sec_q * MICROS_PER_SEC;
		end
		if (cmd.scan_init) begin
			scan_addr_q <= '0;
		end else if (cmd.scan_rd) begin
			scan_addr_q <= scan_addr_q + ADDR_W'(1);
		end
		idx_s1   <= scan_addr_q;
		match_s2 <= rd_match;
		idx_s2   <= idx_s1;
		bus_s2   <= rd_bus;
		ident_s2 <= rd_ident;
		time_s2  <= rd_time;
		dist_s2  <= rd_dist;
		if (m_upd) begin
			mbest_q <= dist_s2;
			midx_q  <= idx_s2;
			mtime_q <= time_s2;
		end
		if (a_upd) begin
			abest_q  <= dist_s2;
			aidx_q   <= idx_s2;
			abus_q   <= bus_s2;
			aident_q <= ident_s2;
			atime_q  <= time_s2;
		end
		if (cmd.load_check) begin
			found        <= rd_match;
			result_index <= ridx_q;
			result_ident <= ident_q;
			result_bus   <= bus_q;
			result_time  <= rd_match ? rd_time : rtime_q;
		end else if (cmd.load_echo) begin
			found        <= 1'b0;
			result_index <= ridx_q;
			result_ident <= ident_q;
			result_bus   <= bus_q;
			result_time  <= rtime_q;
		end else if (cmd.load_scan) begin
			found <= 1'b1;
			if (mfound_q) begin
				result_index <= INDEX_W'(midx_q);
				result_ident <= ident_q;
				result_bus   <= bus_q;
				result_time  <= mtime_q;
			end else begin
				result_index <= INDEX_W'(aidx_q);
				result_ident <= aident_q;
				result_bus   <= abus_q;
				result_time  <= atime_q;
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/frame_timestamp_resolver.sv =====
// Clear: resets the entry count. Append: timestamp multiply, then store write; dropped if the store is full.
// Resolve with index inside the store: store read, then check; with an empty store the request is echoed.
// Resolve by search: one store read per cycle in one pass over the entries, then a pipeline drain.
// One transaction at a time; a pending result does not block the next accept.
// arst_n clears the entry count, controller state and output valid; the store is not cleared.
`default_nettype none
`include "frame_timestamp_resolver_assert.svh"
module frame_timestamp_resolver (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_ready,
	input  wire logic [frt_pkg::OP_W-1:0]           operation,
	input  wire logic [frt_pkg::BUS_W-1:0]          bus_number,
	input  wire logic [frt_pkg::IDENT_W-1:0]        frame_ident,
	input  wire logic [frt_pkg::SEC_W-1:0]          stamp_seconds,
	input  wire logic [frt_pkg::USEC_W-1:0]         stamp_micros,
	input  wire logic [frt_pkg::TIME_W-1:0]         record_time,
	input  wire logic signed [frt_pkg::INDEX_W-1:0] record_index,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_ready,
	output logic                                    found,
	output logic signed [frt_pkg::INDEX_W-1:0]      result_index,
	output logic [frt_pkg::IDENT_W-1:0]             result_ident,
	output logic [frt_pkg::BUS_W-1:0]               result_bus,
	output logic [frt_pkg::TIME_W-1:0]              result_time
);

	import frt_pkg::*;

	cmd_t cmd;
	sts_t sts;

	frt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	frt_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.operation    (operation),
		.bus_number   (bus_number),
		.frame_ident  (frame_ident),
		.stamp_seconds(stamp_seconds),
		.stamp_micros (stamp_micros),
		.record_time  (record_time),
		.record_index (record_index),
		.rsp_valid    (rsp_valid),
		.rsp_ready    (rsp_ready),
		.found        (found),
		.result_index (result_index),
		.result_ident (result_ident),
		.result_bus   (result_bus),
		.result_time  (result_time)
	);

	`FRT_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready)
	`FRT_ASSERT_IMP(a_load_when_free, cmd.load_check || cmd.load_echo || cmd.load_scan, sts.out_free)
	`FRT_ASSERT_IMP(a_no_write_full, cmd.append_wr, !sts.store_full)
	`FRT_ASSERT_IMP(a_scan_nonempty, cmd.scan_rd, !sts.count_zero && !cmd.rd_check)

endmodule
`default_nettype wire
